@@ hdl/cspf_pkg.sv @@
// ----------------------------------------------------------------------------
// cspf_pkg
// shared constants and stage carry types of the contact spring pair force unit
// ----------------------------------------------------------------------------
package cspf_pkg;

   localparam int unsigned SQRT_STAGES = 32;   // one root bit per stage
   localparam int unsigned DIV_STAGES  = 17;   // one quotient bit per stage
   // start edge to the edge that samples rsp_valid
   localparam int unsigned LATENCY     = 6 + SQRT_STAGES + 1 + DIV_STAGES + 3;

   localparam logic [15:0] THR_RESET = 16'd1;
   localparam logic [31:0] DIST_SAT  = 32'hFFFF_FFFF;

   // geometry carried alongside the square root
   typedef struct packed {
      logic        dx_neg;
      logic        dy_neg;
      logic [31:0] adx;
      logic [31:0] ady;
      logic [31:0] rsum;
      logic [31:0] stiff;
      logic        sat;
   } cspf_geom_type;

   // contact data carried alongside the direction dividers
   typedef struct packed {
      logic        dx_neg;
      logic        dy_neg;
      logic        contact;
      logic        dir_ok;
      logic [31:0] distance;
      logic [31:0] overlap;
      logic [31:0] stiff;
   } cspf_ctc_type;

endpackage

@@ hdl/contact_spring_pair_force_unit.sv @@
// ----------------------------------------------------------------------------
// contact_spring_pair_force_unit
// linear spring contact force of one particle pair in 2D, Q16.16, pipelined
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  -------   ---------------------------   ----------------------------------
//  request   start, busy, req_*            word taken when start && !busy
//  result    rsp_valid, rsp_*              one-cycle strobe, cannot be held off
//  csr       csr_wr_en, csr_wr_data        threshold written when csr_wr_en
//
//  one word enters every cycle; busy is always low
//  each result strobes after its word has passed through every stage in turn
//  (6 front stages, 32 root stages of the bit-serial square root, 1 contact
//  stage, 17 divider stages, 3 force stages)
//  reset clears the valid line and loads the threshold with 1; words in
//  flight are dropped
//  the receiver cannot stall, so no stage ever holds
//
module contact_spring_pair_force_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_pos_a_x,
   input  logic signed [31:0] req_pos_a_y,
   input  logic signed [31:0] req_pos_b_x,
   input  logic signed [31:0] req_pos_b_y,
   input  logic signed [31:0] req_rope_a_x,
   input  logic signed [31:0] req_rope_a_y,
   input  logic signed [31:0] req_rope_b_x,
   input  logic signed [31:0] req_rope_b_y,
   input  logic        [31:0] req_sub_step,
   input  logic        [30:0] req_radius_a,
   input  logic        [30:0] req_radius_b,
   input  logic        [31:0] req_stiffness,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_force_b_x,
   output logic signed [31:0] rsp_force_b_y,
   output logic        [31:0] rsp_pair_distance,
   output logic               rsp_in_contact
);

   localparam int unsigned LAT = cspf_pkg::LATENCY;
   localparam int unsigned NSQ = cspf_pkg::SQRT_STAGES;
   localparam int unsigned NDV = cspf_pkg::DIV_STAGES;

   // pipeline never stalls
   assign busy = 1'b0;

   // threshold register
   logic [15:0] thr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= cspf_pkg::THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // valid bits travel one stage per cycle next to the data
   logic [LAT-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start && !busy};
      end
   end
   assign rsp_valid = vld_ff[LAT-1];

   // ---- stage 1: offset times sub-step --------------------------------------
   logic signed [32:0] step_s;
   logic signed [64:0] p_ax_in, p_ay_in, p_bx_in, p_by_in;
   logic signed [64:0] p_ax_ff, p_ay_ff, p_bx_ff, p_by_ff;
   logic signed [31:0] pos_ax_ff, pos_ay_ff, pos_bx_ff, pos_by_ff;
   logic        [31:0] rsum1_ff, stiff1_ff;

   assign step_s  = $signed({1'b0, req_sub_step});
   assign p_ax_in = req_rope_a_x * step_s;
   assign p_ay_in = req_rope_a_y * step_s;
   assign p_bx_in = req_rope_b_x * step_s;
   assign p_by_in = req_rope_b_y * step_s;

   always_ff @(posedge clock) begin
      p_ax_ff   <= p_ax_in;
      p_ay_ff   <= p_ay_in;
      p_bx_ff   <= p_bx_in;
      p_by_ff   <= p_by_in;
      pos_ax_ff <= req_pos_a_x;
      pos_ay_ff <= req_pos_a_y;
      pos_bx_ff <= req_pos_b_x;
      pos_by_ff <= req_pos_b_y;
      rsum1_ff  <= {1'b0, req_radius_a} + {1'b0, req_radius_b};
      stiff1_ff <= req_stiffness;
   end

   // ---- stage 2: moved positions, floor of the scaled offset ----------------
   logic signed [49:0] ax_in, ay_in, bx_in, by_in;
   logic signed [49:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic        [31:0] rsum2_ff, stiff2_ff;

   assign ax_in = {{18{pos_ax_ff[31]}}, pos_ax_ff} + {p_ax_ff[64], p_ax_ff[64:16]};
   assign ay_in = {{18{pos_ay_ff[31]}}, pos_ay_ff} + {p_ay_ff[64], p_ay_ff[64:16]};
   assign bx_in = {{18{pos_bx_ff[31]}}, pos_bx_ff} + {p_bx_ff[64], p_bx_ff[64:16]};
   assign by_in = {{18{pos_by_ff[31]}}, pos_by_ff} + {p_by_ff[64], p_by_ff[64:16]};

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      ay_ff     <= ay_in;
      bx_ff     <= bx_in;
      by_ff     <= by_in;
      rsum2_ff  <= rsum1_ff;
      stiff2_ff <= stiff1_ff;
   end

   // ---- stage 3: difference vector, second minus first ---------------------
   logic signed [50:0] dx_in, dy_in, dx_ff, dy_ff;
   logic        [31:0] rsum3_ff, stiff3_ff;

   assign dx_in = {bx_ff[49], bx_ff} - {ax_ff[49], ax_ff};
   assign dy_in = {by_ff[49], by_ff} - {ay_ff[49], ay_ff};

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      rsum3_ff  <= rsum2_ff;
      stiff3_ff <= stiff2_ff;
   end

   // ---- stage 4: magnitudes, out-of-range flag ------------------------------
   logic [50:0]             mdx, mdy;
   cspf_pkg::cspf_geom_type g4_in, g4_ff;

   always_comb begin
      mdx         = dx_ff[50] ? 51'(-dx_ff) : 51'(dx_ff);
      mdy         = dy_ff[50] ? 51'(-dy_ff) : 51'(dy_ff);
      g4_in.dx_neg = dx_ff[50];
      g4_in.dy_neg = dy_ff[50];
      g4_in.adx    = mdx[31:0];
      g4_in.ady    = mdy[31:0];
      g4_in.rsum   = rsum3_ff;
      g4_in.stiff  = stiff3_ff;
      // a component of 2^32 or more saturates the distance
      g4_in.sat    = (mdx[50:32] != '0) || (mdy[50:32] != '0);
   end

   always_ff @(posedge clock) begin
      g4_ff <= g4_in;
   end

   // ---- stage 5: squares ----------------------------------------------------
   logic [63:0]             sqx_ff, sqy_ff;
   cspf_pkg::cspf_geom_type g5_ff;

   always_ff @(posedge clock) begin
      sqx_ff <= g4_ff.adx * g4_ff.adx;
      sqy_ff <= g4_ff.ady * g4_ff.ady;
      g5_ff  <= g4_ff;
   end

   // ---- stage 6: sum of squares, root pipeline entry ------------------------
   logic [64:0]             sum_in;
   logic [34:0]             sq_rem_ff  [0:NSQ];
   logic [31:0]             sq_root_ff [0:NSQ];
   logic [63:0]             sq_x_ff    [0:NSQ];
   cspf_pkg::cspf_geom_type sq_g_ff    [0:NSQ];
   cspf_pkg::cspf_geom_type g6_in;

   always_comb begin
      sum_in    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      g6_in     = g5_ff;
      // sum past 64 bits saturates too
      g6_in.sat = g5_ff.sat || sum_in[64];
   end

   always_ff @(posedge clock) begin
      sq_rem_ff[0]  <= '0;
      sq_root_ff[0] <= '0;
      sq_x_ff[0]    <= sum_in[63:0];
      sq_g_ff[0]    <= g6_in;
   end

   // ---- square root, one result bit per stage -------------------------------
   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      logic [34:0] sq_try, sq_trial;
      logic [34:0] rem_in;
      logic [31:0] root_in;

      always_comb begin
         sq_try   = {sq_rem_ff[k][32:0], sq_x_ff[k][63:62]};
         sq_trial = {1'b0, sq_root_ff[k], 2'b01};
         if (sq_try >= sq_trial) begin
            rem_in  = sq_try - sq_trial;
            root_in = {sq_root_ff[k][30:0], 1'b1};
         end else begin
            rem_in  = sq_try;
            root_in = {sq_root_ff[k][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         sq_rem_ff[k+1]  <= rem_in;
         sq_root_ff[k+1] <= root_in;
         sq_x_ff[k+1]    <= {sq_x_ff[k][61:0], 2'b00};
         sq_g_ff[k+1]    <= sq_g_ff[k];
      end
   end

   // ---- contact stage: distance, overlap, divider entry ---------------------
   logic [31:0]            dist_c;
   cspf_pkg::cspf_ctc_type c_in;
   logic [31:0]            dvx_rem_ff [0:NDV];
   logic [31:0]            dvy_rem_ff [0:NDV];
   logic [16:0]            dvx_q_ff   [0:NDV];
   logic [16:0]            dvy_q_ff   [0:NDV];
   logic                   dvx_lsb_ff, dvy_lsb_ff;
   cspf_pkg::cspf_ctc_type dv_c_ff    [0:NDV];

   always_comb begin
      dist_c    = sq_g_ff[NSQ].sat ? cspf_pkg::DIST_SAT : sq_root_ff[NSQ];
      c_in.dx_neg  = sq_g_ff[NSQ].dx_neg;
      c_in.dy_neg  = sq_g_ff[NSQ].dy_neg;
      c_in.contact = !sq_g_ff[NSQ].sat && (dist_c < sq_g_ff[NSQ].rsum);
      // at or below the threshold the direction is zero
      c_in.dir_ok  = c_in.contact && (dist_c > {16'd0, thr_ff});
      c_in.distance = dist_c;
      c_in.overlap = sq_g_ff[NSQ].rsum - dist_c;
      c_in.stiff   = sq_g_ff[NSQ].stiff;
   end

   // |d| <= dist, so the quotient of |d|*65536 / dist fits 17 bits and the
   // divider starts from |d| >> 1
   always_ff @(posedge clock) begin
      dvx_rem_ff[0] <= {1'b0, sq_g_ff[NSQ].adx[31:1]};
      dvy_rem_ff[0] <= {1'b0, sq_g_ff[NSQ].ady[31:1]};
      dvx_lsb_ff    <= sq_g_ff[NSQ].adx[0];
      dvy_lsb_ff    <= sq_g_ff[NSQ].ady[0];
      dvx_q_ff[0]   <= '0;
      dvy_q_ff[0]   <= '0;
      dv_c_ff[0]    <= c_in;
   end

   // ---- direction dividers, one quotient bit per stage ----------------------
   for (genvar j = 0; j < NDV; j++) begin : g_div
      logic        bx, by;
      logic [32:0] tx, ty;
      logic [31:0] rx_in, ry_in;
      logic [16:0] qx_in, qy_in;

      always_comb begin
         // only the first step brings in a dividend bit, the rest are zeros
         bx = (j == 0) ? dvx_lsb_ff : 1'b0;
         by = (j == 0) ? dvy_lsb_ff : 1'b0;
         tx = {dvx_rem_ff[j], bx};
         ty = {dvy_rem_ff[j], by};
         if (tx >= {1'b0, dv_c_ff[j].distance}) begin
            rx_in = 32'(tx - {1'b0, dv_c_ff[j].distance});
            qx_in = {dvx_q_ff[j][15:0], 1'b1};
         end else begin
            rx_in = tx[31:0];
            qx_in = {dvx_q_ff[j][15:0], 1'b0};
         end
         if (ty >= {1'b0, dv_c_ff[j].distance}) begin
            ry_in = 32'(ty - {1'b0, dv_c_ff[j].distance});
            qy_in = {dvy_q_ff[j][15:0], 1'b1};
         end else begin
            ry_in = ty[31:0];
            qy_in = {dvy_q_ff[j][15:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         dvx_rem_ff[j+1] <= rx_in;
         dvy_rem_ff[j+1] <= ry_in;
         dvx_q_ff[j+1]   <= qx_in;
         dvy_q_ff[j+1]   <= qy_in;
         dv_c_ff[j+1]    <= dv_c_ff[j];
      end
   end

   // ---- force stage 1: magnitude = overlap * stiffness ----------------------
   logic [63:0]            mag_prod;
   logic [47:0]            mag_ff;
   logic [16:0]            f1_qx_ff, f1_qy_ff;
   cspf_pkg::cspf_ctc_type f1_c_ff;

   assign mag_prod = dv_c_ff[NDV].overlap * dv_c_ff[NDV].stiff;

   always_ff @(posedge clock) begin
      mag_ff   <= mag_prod[63:16];
      f1_qx_ff <= dvx_q_ff[NDV];
      f1_qy_ff <= dvy_q_ff[NDV];
      f1_c_ff  <= dv_c_ff[NDV];
   end

   // ---- force stage 2: magnitude times direction ----------------------------
   logic [64:0]            fpx_prod, fpy_prod;
   logic [48:0]            fpx_ff, fpy_ff;
   cspf_pkg::cspf_ctc_type f2_c_ff;

   assign fpx_prod = mag_ff * f1_qx_ff;
   assign fpy_prod = mag_ff * f1_qy_ff;

   always_ff @(posedge clock) begin
      fpx_ff  <= fpx_prod[64:16];
      fpy_ff  <= fpy_prod[64:16];
      f2_c_ff <= f1_c_ff;
   end

   // ---- force stage 3: sign, saturation, result register --------------------
   logic [31:0] fx_in, fy_in;

   always_comb begin
      if (!f2_c_ff.dir_ok) begin
         fx_in = '0;
      end else if (!f2_c_ff.dx_neg) begin
         fx_in = (fpx_ff > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : fpx_ff[31:0];
      end else begin
         fx_in = (fpx_ff > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-fpx_ff[31:0]);
      end
      if (!f2_c_ff.dir_ok) begin
         fy_in = '0;
      end else if (!f2_c_ff.dy_neg) begin
         fy_in = (fpy_ff > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : fpy_ff[31:0];
      end else begin
         fy_in = (fpy_ff > 49'h0_8000_0000) ? 32'h8000_0000 : 32'(-fpy_ff[31:0]);
      end
   end

   always_ff @(posedge clock) begin
      rsp_force_b_x     <= $signed(fx_in);
      rsp_force_b_y     <= $signed(fy_in);
      rsp_pair_distance <= f2_c_ff.distance;
      rsp_in_contact    <= f2_c_ff.contact;
   end

endmodule

@@ hdl/cspf_checker.sv @@
// ----------------------------------------------------------------------------
// cspf_checker
// port-level checks of the contact spring pair force unit
// ----------------------------------------------------------------------------
module cspf_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_force_b_x,
   input logic signed [31:0] rsp_force_b_y,
   input logic        [31:0] rsp_pair_distance,
   input logic               rsp_in_contact
);

   // every result traces back to an accepted word at the start edge that LATENCY names
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, cspf_pkg::LATENCY))
      else $error("result without matching request");

   // no contact means no force
   a_no_force: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_contact |-> rsp_force_b_x == 0 && rsp_force_b_y == 0)
      else $error("force without contact");

   // a saturated distance is never a contact
   a_sat_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_distance == cspf_pkg::DIST_SAT |-> !rsp_in_contact)
      else $error("contact at saturated distance");

   // reset flushes words in flight
   a_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

endmodule

bind contact_spring_pair_force_unit cspf_checker u_cspf_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_force_b_x     (rsp_force_b_x),
   .rsp_force_b_y     (rsp_force_b_y),
   .rsp_pair_distance (rsp_pair_distance),
   .rsp_in_contact    (rsp_in_contact)
);
